### rtl/cffwd_pkg.sv
// Shared types and constants for the CAN frame FIFO and weight decoder.
`default_nettype none

package cffwd_pkg;

  localparam int unsigned ID_W    = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned ENTRY_W = ID_W + 2 * DATA_W;

  localparam logic [ID_W-1:0] WEIGHT_ID_FIRST = 11'h302;
  localparam logic [ID_W-1:0] WEIGHT_ID_LAST  = 11'h308;

  typedef enum logic [1:0] {
    REQ_RX    = 2'd0,
    REQ_POP   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // Decoded request as it sits in the command queue
  typedef struct packed {
    req_e              req;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] data_high;
    logic [DATA_W-1:0] data_low;
    logic [CHAN_W-1:0] channel;
    logic              weight_hit;
    logic [CHAN_W-1:0] weight_base;
  } cmd_t;

  typedef struct packed {
    logic                     ok;
    logic [ID_W-1:0]          out_id;
    logic [DATA_W-1:0]        out_high;
    logic [DATA_W-1:0]        out_low;
    logic signed [DATA_W-1:0] weight_value;
    logic [CHAN_W-1:0]        chan_mark;
    logic [LEVEL_W-1:0]       fifo_level;
    logic                     dropped_oldest;
    logic                     connected;
  } res_t;

endpackage

`default_nettype wire

### rtl/can_frame_fifo_weight_decoder_top.sv
// CAN receive frame FIFO with channel weight decoding.
//
// Input channel (in_valid_i/in_ready_o) carries one request word: a received
// frame, a pop of the oldest held frame, a weight read or a FIFO clear.
// Output channel (out_valid_o/out_ready_i) returns exactly one result word per
// request, in request order.
// Accepted words enter a two-entry command queue; the back end takes one per
// cycle while the output register is free and no pop is in progress. A frame,
// weight read or clear loads its result into the output register at the edge
// that takes it from the queue; a pop that finds a frame is read first into
// the registered read port of the frame memory and loaded from there in ST_POP.
// Sustained rate is one word per cycle while the receiver keeps up; a
// successful pop holds off the next word until its result is loaded.
// Reset empties the FIFO, zeroes the weights, the channel mark and the
// connected flag; stored frames are undefined until written.
// When the receiver stalls, the result word holds in the output register, the
// back end stops and the queue fills; in_ready_o drops once it holds two words.
`default_nettype none

module can_frame_fifo_weight_decoder_top
  import cffwd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH   = 8,
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [ID_W-1:0]          frame_id_i,
  input  wire logic [DATA_W-1:0]        data_high_i,
  input  wire logic [DATA_W-1:0]        data_low_i,
  input  wire logic [CHAN_W-1:0]        channel_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          ok_o,
  output logic [ID_W-1:0]               out_id_o,
  output logic [DATA_W-1:0]             out_high_o,
  output logic [DATA_W-1:0]             out_low_o,
  output logic signed [DATA_W-1:0]      weight_value_o,
  output logic [CHAN_W-1:0]             chan_mark_o,
  output logic [LEVEL_W-1:0]            fifo_level_o,
  output logic                          dropped_oldest_o,
  output logic                          connected_o
);

  cmd_t front_cmd, queue_cmd;
  logic queue_valid, queue_ready;
  res_t res;

  cffwd_front u_front (
    .req_type_i  (req_type_i),
    .frame_id_i  (frame_id_i),
    .data_high_i (data_high_i),
    .data_low_i  (data_low_i),
    .channel_i   (channel_i),
    .cmd_o       (front_cmd)
  );

  cffwd_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  cffwd_back #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign ok_o             = res.ok;
  assign out_id_o         = res.out_id;
  assign out_high_o       = res.out_high;
  assign out_low_o        = res.out_low;
  assign weight_value_o   = res.weight_value;
  assign chan_mark_o      = res.chan_mark;
  assign fifo_level_o     = res.fifo_level;
  assign dropped_oldest_o = res.dropped_oldest;
  assign connected_o      = res.connected;

endmodule

`default_nettype wire

### rtl/cffwd_front.sv
// Front end: decodes an incoming request and classifies weight-carrying frames.
`default_nettype none

module cffwd_front
  import cffwd_pkg::*;
(
  input  wire logic [1:0]        req_type_i,
  input  wire logic [ID_W-1:0]   frame_id_i,
  input  wire logic [DATA_W-1:0] data_high_i,
  input  wire logic [DATA_W-1:0] data_low_i,
  input  wire logic [CHAN_W-1:0] channel_i,
  output cmd_t                   cmd_o
);

  logic [ID_W-1:0] id_offset;
  logic            hit;

  assign hit       = (frame_id_i >= WEIGHT_ID_FIRST) && (frame_id_i <= WEIGHT_ID_LAST);
  assign id_offset = frame_id_i - WEIGHT_ID_FIRST;

  always_comb begin
    cmd_o.req         = req_e'(req_type_i);
    cmd_o.frame_id    = frame_id_i;
    cmd_o.data_high   = data_high_i;
    cmd_o.data_low    = data_low_i;
    cmd_o.channel     = channel_i;
    cmd_o.weight_hit  = hit & (req_e'(req_type_i) == REQ_RX);
    // two channels per weight frame
    cmd_o.weight_base = {id_offset[2:0], 1'b0};
  end

endmodule

`default_nettype wire

### rtl/cffwd_cmd_queue.sv
// Two-entry command queue between the front end and the execution back end.
`default_nettype none

module cffwd_cmd_queue
  import cffwd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

### rtl/cffwd_back.sv
// Back end: frame ring buffer, weight store, counters and the result register.
`default_nettype none

module cffwd_back
  import cffwd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH   = 8,
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_POP = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic [ENTRY_W-1:0] mem_q [FIFO_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we, rd_en;

  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d, wptr_nxt, rptr_nxt;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W+3:0]   cnt_ext;
  logic [CHAN_W-1:0]  mark_q, mark_d;
  logic               link_q, link_d;

  logic [DATA_W-1:0]  weight_q [MAX_CHANNELS];
  logic [DATA_W-1:0]  rd_weight;
  logic               wt_we;
  logic [CHAN_W-1:0]  base_p1, base_p2;

  logic               out_free, res_load, drop;
  res_t               res_q, res_d;

  assign out_free    = ~res_valid_o | res_ready_i;
  assign res_o       = res_q;
  assign base_p1     = cmd_i.weight_base + CHAN_W'(1);
  assign base_p2     = cmd_i.weight_base + CHAN_W'(2);
  assign wptr_nxt    = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
  assign rptr_nxt    = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
  assign cnt_ext     = {4'b0, cnt_d};

  always_comb begin
    rd_weight = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (cmd_i.channel == CHAN_W'(i)) rd_weight = weight_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    cnt_d       = cnt_q;
    mark_d      = mark_q;
    link_d      = link_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    wt_we       = 1'b0;
    drop        = 1'b0;
    res_load    = 1'b0;
    cmd_ready_o = 1'b0;

    case (state_q)
      ST_RUN: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          case (cmd_i.req)
            REQ_RX: begin
              mem_we   = 1'b1;
              wptr_d   = wptr_nxt;
              if (cnt_q != CNT_W'(FIFO_DEPTH)) begin
                cnt_d = cnt_q + CNT_W'(1);
              end else begin
                // full: advance past the oldest word
                rptr_d = rptr_nxt;
                drop   = 1'b1;
              end
              if (cmd_i.weight_hit) begin
                wt_we = 1'b1;
                if (base_p2 > mark_q) mark_d = base_p2;
              end
              link_d   = 1'b1;
              res_load = 1'b1;
            end
            REQ_POP: begin
              if (cnt_q == '0) begin
                res_load = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rptr_d  = rptr_nxt;
                cnt_d   = cnt_q - CNT_W'(1);
                state_d = ST_POP;
              end
            end
            REQ_CLEAR: begin
              wptr_d   = '0;
              rptr_d   = '0;
              cnt_d    = '0;
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    res_d.ok             = 1'b1;
    res_d.out_id         = '0;
    res_d.out_high       = '0;
    res_d.out_low        = '0;
    res_d.weight_value   = '0;
    res_d.chan_mark      = mark_d;
    res_d.fifo_level     = cnt_ext[LEVEL_W-1:0];
    res_d.dropped_oldest = drop;
    res_d.connected      = link_d;
    if (state_q == ST_POP) begin
      res_d.out_id   = rd_q[ENTRY_W-1 -: ID_W];
      res_d.out_high = rd_q[2*DATA_W-1 -: DATA_W];
      res_d.out_low  = rd_q[DATA_W-1:0];
    end else if (cmd_i.req == REQ_POP) begin
      res_d.ok = 1'b0;
    end else if (cmd_i.req == REQ_READ) begin
      res_d.weight_value = rd_weight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      mark_q      <= '0;
      link_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      cnt_q   <= cnt_d;
      mark_q  <= mark_d;
      link_q  <= link_d;
      if (res_load) begin
        res_valid_o <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) weight_q[i] <= '0;
    end else if (wt_we) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (cmd_i.weight_base == CHAN_W'(i)) begin
          weight_q[i] <= cmd_i.data_high;
        end else if (base_p1 == CHAN_W'(i)) begin
          weight_q[i] <= cmd_i.data_low;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wptr_q] <= {cmd_i.frame_id, cmd_i.data_high, cmd_i.data_low};
    if (rd_en)  rd_q <= mem_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

endmodule

`default_nettype wire

### rtl/cffwd_checker.sv
// Port-level checker for the CAN frame FIFO top level, with its bind.
`default_nettype none

module cffwd_checker
  import cffwd_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic                     ok_i,
  input wire logic [ID_W-1:0]          out_id_i,
  input wire logic [DATA_W-1:0]        out_high_i,
  input wire logic [DATA_W-1:0]        out_low_i,
  input wire logic signed [DATA_W-1:0] weight_value_i,
  input wire logic [CHAN_W-1:0]        chan_mark_i,
  input wire logic [LEVEL_W-1:0]       fifo_level_i,
  input wire logic                     connected_i
);

  logic              seen_conn_q;
  logic [CHAN_W-1:0] mark_q;

  // track what delivered words have shown so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_conn_q <= 1'b0;
      mark_q      <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_conn_q <= seen_conn_q | connected_i;
      mark_q      <= chan_mark_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) && $stable(out_id_i)
      && $stable(out_high_i) && $stable(out_low_i) && $stable(weight_value_i)
      && $stable(fifo_level_i))
    else $error("result word changed while stalled");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> out_id_i == '0 && out_high_i == '0 && out_low_i == '0
      && fifo_level_i == '0)
    else $error("failed pop with nonzero frame or level");

  a_conn_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_conn_q |-> connected_i)
    else $error("connected flag fell");

  a_mark_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chan_mark_i >= mark_q)
    else $error("channel mark decreased");

endmodule

bind can_frame_fifo_weight_decoder_top cffwd_checker u_cffwd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .ok_i             (ok_o),
  .out_id_i         (out_id_o),
  .out_high_i       (out_high_o),
  .out_low_i        (out_low_o),
  .weight_value_i   (weight_value_o),
  .chan_mark_i      (chan_mark_o),
  .fifo_level_i     (fifo_level_o),
  .connected_i      (connected_o)
);

`default_nettype wire

### tb/can_frame_fifo_weight_decoder_top_test.sv
// Self-checking testbench for the CAN frame FIFO and channel weight decoder.
module can_frame_fifo_weight_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cffwd_pkg::*;

  localparam int unsigned RING_DEPTH   = 8;
  localparam int unsigned CHAN_COUNT   = 14;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned LONG_HOLD    = 400;

  // Tracks the frame ring and weight store; predicts one result per request word
  class rx_fifo_predictor;
    logic [ID_W-1:0]     ring_ids[RING_DEPTH];
    logic [2*DATA_W-1:0] ring_payloads[RING_DEPTH];
    int unsigned         wr_slot;
    int unsigned         rd_slot;
    int unsigned         held;
    logic [DATA_W-1:0]   weights[CHAN_COUNT];
    logic [CHAN_W-1:0]   mark;
    bit                  linked;
    res_t                pending_replies[$];
    int unsigned         failures;

    function new();
      wr_slot  = 0;
      rd_slot  = 0;
      held     = 0;
      mark     = '0;
      linked   = 1'b0;
      failures = 0;
      foreach (weights[i]) weights[i] = '0;
    endfunction

    function void note_request(req_e req, logic [ID_W-1:0] id, logic [DATA_W-1:0] hi,
                               logic [DATA_W-1:0] lo, logic [CHAN_W-1:0] ch);
      res_t        r;
      int unsigned base;
      r    = '0;
      r.ok = 1'b1;
      case (req)
        REQ_RX: begin
          ring_ids[wr_slot]      = id;
          ring_payloads[wr_slot] = {hi, lo};
          wr_slot = (wr_slot + 1) % RING_DEPTH;
          if (held < RING_DEPTH) begin
            held++;
          end else begin
            // full ring: the oldest frame is overwritten
            rd_slot = (rd_slot + 1) % RING_DEPTH;
            r.dropped_oldest = 1'b1;
          end
          if (id >= WEIGHT_ID_FIRST && id <= WEIGHT_ID_LAST) begin
            base = (id - WEIGHT_ID_FIRST) * 2;
            if (base < CHAN_COUNT) weights[base] = hi;
            if (base + 1 < CHAN_COUNT) weights[base + 1] = lo;
            if (base + 2 > mark) mark = CHAN_W'(base + 2);
          end
          linked = 1'b1;
        end
        REQ_POP: begin
          if (held == 0) begin
            r.ok = 1'b0;
          end else begin
            r.out_id   = ring_ids[rd_slot];
            r.out_high = ring_payloads[rd_slot][2*DATA_W-1:DATA_W];
            r.out_low  = ring_payloads[rd_slot][DATA_W-1:0];
            rd_slot = (rd_slot + 1) % RING_DEPTH;
            held--;
          end
        end
        REQ_READ: begin
          if (ch < CHAN_COUNT) r.weight_value = weights[ch];
        end
        default: begin
          wr_slot = 0;
          rd_slot = 0;
          held    = 0;
        end
      endcase
      r.chan_mark      = mark;
      r.fifo_level     = LEVEL_W'(held);
      r.connected      = linked;
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_replies.size() == 0) begin
        $error("result word with no request outstanding");
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("out_id", want.out_id, got.out_id);
      compare_field("out_high", want.out_high, got.out_high);
      compare_field("out_low", want.out_low, got.out_low);
      compare_field("weight_value", want.weight_value, got.weight_value);
      compare_field("chan_mark", want.chan_mark, got.chan_mark);
      compare_field("fifo_level", want.fifo_level, got.fifo_level);
      compare_field("dropped_oldest", want.dropped_oldest, got.dropped_oldest);
      compare_field("connected", want.connected, got.connected);
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               req_type_i = '0;
  logic [ID_W-1:0]          frame_id_i = '0;
  logic [DATA_W-1:0]        data_high_i = '0;
  logic [DATA_W-1:0]        data_low_i = '0;
  logic [CHAN_W-1:0]        channel_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     ok_o;
  logic [ID_W-1:0]          out_id_o;
  logic [DATA_W-1:0]        out_high_o;
  logic [DATA_W-1:0]        out_low_o;
  logic signed [DATA_W-1:0] weight_value_o;
  logic [CHAN_W-1:0]        chan_mark_o;
  logic [LEVEL_W-1:0]       fifo_level_o;
  logic                     dropped_oldest_o;
  logic                     connected_o;

  rx_fifo_predictor sb = new();
  int unsigned      cycle_count = 0;
  bit               sender_steady = 1'b0;

  can_frame_fifo_weight_decoder_top #(
    .FIFO_DEPTH  (RING_DEPTH),
    .MAX_CHANNELS(CHAN_COUNT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .frame_id_i      (frame_id_i),
    .data_high_i     (data_high_i),
    .data_low_i      (data_low_i),
    .channel_i       (channel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .out_id_o        (out_id_o),
    .out_high_o      (out_high_o),
    .out_low_o       (out_low_o),
    .weight_value_o  (weight_value_o),
    .chan_mark_o     (chan_mark_o),
    .fifo_level_o    (fifo_level_o),
    .dropped_oldest_o(dropped_oldest_o),
    .connected_o     (connected_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request word and hold it until accepted
  task automatic send_word(req_e req, logic [ID_W-1:0] id, logic [DATA_W-1:0] hi,
                           logic [DATA_W-1:0] lo, logic [CHAN_W-1:0] ch);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    frame_id_i  <= id;
    data_high_i <= hi;
    data_low_i  <= lo;
    channel_i   <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req, id, hi, lo, ch);
  endtask

  task automatic collect_results();
    int unsigned stall;
    int unsigned taken;
    bit          steady;
    res_t        got;
    taken  = 0;
    steady = 1'b0;
    forever begin
      if (taken % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 15);
      // hold off long enough for the command queue to fill and stall the input
      if (taken == 300) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.ok             = ok_o;
      got.out_id         = out_id_o;
      got.out_high       = out_high_o;
      got.out_low        = out_low_o;
      got.weight_value   = weight_value_o;
      got.chan_mark      = chan_mark_o;
      got.fifo_level     = fifo_level_o;
      got.dropped_oldest = dropped_oldest_o;
      got.connected      = connected_o;
      sb.check_result(got);
      taken++;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return ID_W'($urandom_range(WEIGHT_ID_FIRST, WEIGHT_ID_LAST));
    if (sel == 4) begin
      return $urandom_range(0, 1) ? ID_W'(WEIGHT_ID_FIRST - ID_W'(1))
                                  : ID_W'(WEIGHT_ID_LAST + ID_W'(1));
    end
    if (sel == 5) return $urandom_range(0, 1) ? '0 : '1;
    return ID_W'($urandom_range(0, 2047));
  endfunction

  initial begin
    int unsigned rx_share;
    int unsigned roll;
    req_e        req;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_results();
    join_none

    // directed: empty pop, weight edges, reads past the channel count, overflow, clear
    send_word(REQ_POP,   '0, '0, '0, '0);
    send_word(REQ_READ,  '0, '0, '0, 4'd0);
    send_word(REQ_RX,    11'h302, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_word(REQ_RX,    11'h308, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
    send_word(REQ_READ,  '0, '0, '0, 4'd0);
    send_word(REQ_READ,  '0, '0, '0, 4'd1);
    send_word(REQ_READ,  '0, '0, '0, 4'd12);
    send_word(REQ_READ,  '0, '0, '0, 4'd13);
    send_word(REQ_READ,  '0, '0, '0, 4'd14);
    send_word(REQ_READ,  '0, '0, '0, 4'd15);
    send_word(REQ_RX,    11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_word(REQ_RX,    11'h000, 32'h0000_0000, 32'h0000_0000, '0);
    send_word(REQ_RX,    11'h301, 32'h1234_5678, 32'h9ABC_DEF0, '0);
    send_word(REQ_RX,    11'h309, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0);
    send_word(REQ_RX,    11'h305, 32'hDEAD_BEEF, 32'hCAFE_F00D, '0);
    send_word(REQ_RX,    11'h303, 32'h5555_5555, 32'hAAAA_AAAA, '0);
    send_word(REQ_RX,    11'h304, 32'hAAAA_AAAA, 32'h5555_5555, '0);
    send_word(REQ_RX,    11'h2AA, 32'h0000_0001, 32'h8000_0001, '0);
    send_word(REQ_POP,   '0, '0, '0, '0);
    send_word(REQ_CLEAR, '0, '0, '0, '0);
    send_word(REQ_POP,   '0, '0, '0, '0);
    send_word(REQ_RX,    11'h306, 32'h0BAD_F00D, 32'h1357_9BDF, '0);
    send_word(REQ_POP,   '0, '0, '0, '0);
    send_word(REQ_READ,  '0, '0, '0, 4'd10);

    rx_share = 45;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      // alternate fill-heavy, drain-heavy and balanced stretches
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_share = 75;
          1:       rx_share = 20;
          default: rx_share = 45;
        endcase
        sender_steady = ($urandom_range(0, 2) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) req = REQ_CLEAR;
      else if (roll < 4 + rx_share) req = REQ_RX;
      else if ($urandom_range(0, 9) < 7) req = REQ_POP;
      else req = REQ_READ;
      send_word(req, pick_id(), pick_data(), pick_data(),
                ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(14, 15))
                                            : CHAN_W'($urandom_range(0, 13)));
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
